@@ hdl/encoder_position_and_rpm_meter_defines.svh @@
// Assertion macros shared by the encoder meter modules.
// Depends on i_clk and i_rst_n in the including module's scope.
`ifndef ENCODER_POSITION_AND_RPM_METER_DEFINES_SVH
`define ENCODER_POSITION_AND_RPM_METER_DEFINES_SVH

// ante holds in a cycle -> cons holds in the same cycle
`define EPRM_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante holds in a cycle -> cons holds in the next cycle
`define EPRM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/eprm_pkg.sv @@
// Types and constants for the encoder position and rpm meter.
// No dependencies; imported by the calc unit and the top level.
`default_nettype none

package eprm_pkg;

    localparam int TS_W      = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int TICKS_W   = 17;
    localparam int FACTOR_W  = 26;
    localparam int SPEED_W   = 31;
    localparam int CNT_W     = 5;

    localparam logic [FACTOR_W-1:0] RPM_NUMERATOR = 26'd60000000;
    localparam logic [SPEED_W-1:0]  SPEED_MAX     = 31'h7FFF_FFFF;

    // last iteration index of each iterative phase
    localparam logic [CNT_W-1:0] FACTOR_LAST = 5'd25;
    localparam logic [CNT_W-1:0] DIV_LAST    = 5'd30;

    localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_INTERVAL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_PER_REV  = 1'b1;

    localparam logic [CFG_W-1:0] UPDATE_INTERVAL_RST = 16'd100;
    localparam logic [CFG_W-1:0] COUNTS_PER_REV_RST  = 16'd1024;

    typedef struct packed {
        logic [TS_W-1:0] timestamp_us;
        logic            direction_reverse;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0]   position;
        logic [SPEED_W-1:0]   rpm;
        logic                 speed_updated;
    } t_out_word;

    typedef struct packed {
        logic start;
        logic ack;
    } t_calc_ctl;

    typedef struct packed {
        logic               done;
        logic [SPEED_W-1:0] speed;
    } t_calc_sts;

endpackage

`default_nettype wire

@@ hdl/encoder_position_and_rpm_meter.sv @@
// Channel   | valid       | ready       | word
// ----------+-------------+-------------+--------------------------------
// input     | i_in_valid  | o_in_ready  | i_in_word  (t_in_word)
// output    | o_out_valid | i_out_ready | o_out_word (t_out_word)
// config    | i_cfg_we    | -           | i_cfg_idx, i_cfg_data
//
// A tick with no recompute is taken at once; the next may follow as its word goes.
// A recompute holds o_in_ready low through 3 setup steps, 26 steps of the
// 60e6/cpr division, 26 multiply steps, a saturation check and 31 quotient steps,
// all on one shared adder, then the hand-over of the word; the quotient steps
// are skipped when the speed saturates. A waiting output word delays the hand-over.
// Synchronous active-low reset; an output word waiting for ready holds
// new input off only when the next word has nowhere to go.
// Depends on eprm_pkg, eprm_calc, eprm_alu and the defines header.
`default_nettype none
`include "encoder_position_and_rpm_meter_defines.svh"

module encoder_position_and_rpm_meter #(
    parameter int POSITION_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  eprm_pkg::t_in_word             i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output eprm_pkg::t_out_word            o_out_word,
    input  logic                           i_cfg_we,
    input  logic [eprm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [eprm_pkg::CFG_W-1:0]     i_cfg_data
);
    import eprm_pkg::*;

    localparam int PW = POSITION_WIDTH;

    logic [CFG_W-1:0]   r_interval, r_cpr;
    logic [PW-1:0]      r_pos, n_pos;
    logic [PW-1:0]      r_ref_pos, n_ref_pos;
    logic [TS_W-1:0]    r_ref_time, n_ref_time;
    logic [TICKS_W-1:0] r_ticks, n_ticks;
    logic [SPEED_W-1:0] r_last_speed, n_last_speed;
    logic               r_busy, n_busy;
    logic               r_out_valid, n_out_valid;
    t_out_word          r_out_word, n_out_word;

    logic               w_in_acc, w_close, w_recompute;
    logic [PW-1:0]      w_pos_step;
    logic [TICKS_W-1:0] w_ticks_inc;
    logic signed [PW-1:0] w_pos_new_s, w_pos_cur_s;
    t_calc_ctl          w_ctl;
    t_calc_sts          w_sts;

    assign o_in_ready = !r_busy && (!r_out_valid || i_out_ready);
    assign w_in_acc   = i_in_valid && o_in_ready;

    // +1 forward, all ones (-1) reverse
    assign w_pos_step  = r_pos + {{(PW-1){i_in_word.direction_reverse}}, 1'b1};
    assign w_ticks_inc = r_ticks + TICKS_W'(1);
    assign w_close     = w_ticks_inc > TICKS_W'(r_interval);
    assign w_recompute = w_close && (r_ref_time < i_in_word.timestamp_us);
    assign w_pos_new_s = w_pos_step;
    assign w_pos_cur_s = r_pos;

    assign w_ctl.start = w_in_acc && w_recompute;
    assign w_ctl.ack   = w_sts.done && (!r_out_valid || i_out_ready);

    eprm_calc #(.PW(PW)) u_calc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_pos      (w_pos_step),
        .i_ref_pos  (r_ref_pos),
        .i_ts       (i_in_word.timestamp_us),
        .i_ref_time (r_ref_time),
        .i_cpr      (r_cpr),
        .o_sts      (w_sts)
    );

    always_comb begin
        n_pos        = r_pos;
        n_ref_pos    = r_ref_pos;
        n_ref_time   = r_ref_time;
        n_ticks      = r_ticks;
        n_last_speed = r_last_speed;
        n_busy       = r_busy;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_word   = r_out_word;
        if (w_in_acc) begin
            n_pos   = w_pos_step;
            n_ticks = w_ticks_inc;
            if (w_close) begin
                n_ref_time = i_in_word.timestamp_us;
                n_ref_pos  = w_pos_step;
                n_ticks    = '0;
            end
            if (w_recompute) begin
                // hold the word until the speed unit finishes
                n_busy = 1'b1;
            end else begin
                n_out_word.position      = 32'(w_pos_new_s);
                n_out_word.rpm           = r_last_speed;
                n_out_word.speed_updated = 1'b0;
                n_out_valid              = 1'b1;
            end
        end else if (w_ctl.ack) begin
            n_last_speed             = w_sts.speed;
            n_busy                   = 1'b0;
            n_out_word.position      = 32'(w_pos_cur_s);
            n_out_word.rpm           = w_sts.speed;
            n_out_word.speed_updated = 1'b1;
            n_out_valid              = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval   <= UPDATE_INTERVAL_RST;
            r_cpr        <= COUNTS_PER_REV_RST;
            r_pos        <= '0;
            r_ref_pos    <= '0;
            r_ref_time   <= '0;
            r_ticks      <= '0;
            r_last_speed <= '0;
            r_busy       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_UPDATE_INTERVAL: r_interval <= i_cfg_data;
                    CFG_COUNTS_PER_REV:  r_cpr      <= i_cfg_data;
                    default:             r_interval <= r_interval;
                endcase
            end
            r_pos        <= n_pos;
            r_ref_pos    <= n_ref_pos;
            r_ref_time   <= n_ref_time;
            r_ticks      <= n_ticks;
            r_last_speed <= n_last_speed;
            r_busy       <= n_busy;
            r_out_valid  <= n_out_valid;
        end
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `EPRM_ASSERT_IMPLY(a_busy_stall, r_busy, !o_in_ready, "input taken during speed update")
    `EPRM_ASSERT_IMPLY(a_speed_match, r_out_valid, r_out_word.rpm == r_last_speed, "stale rpm")
    `EPRM_ASSERT_NEXT(a_window_clear, w_in_acc && w_close, r_ticks == '0, "tick count kept")

endmodule

`default_nettype wire

@@ hdl/eprm_alu.sv @@
// Shared add/subtract unit of the speed calculation.
// No dependencies; o_ge is the carry out, a >= b when subtracting.
`default_nettype none

module eprm_alu #(
    parameter int W = 58
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic         i_sub,
    output logic [W-1:0] o_sum,
    output logic         o_ge
);

    logic [W:0] w_full;

    assign w_full = {1'b0, i_a} + {1'b0, (i_sub ? ~i_b : i_b)} + {{W{1'b0}}, i_sub};
    assign o_sum  = w_full[W-1:0];
    assign o_ge   = w_full[W];

endmodule

`default_nettype wire

@@ hdl/eprm_calc.sv @@
// Speed sequencer: dt, |position delta|, 60e6/cpr, product and quotient, all
// on one shared adder. Depends on eprm_pkg, eprm_alu and the defines header.
`default_nettype none
`include "encoder_position_and_rpm_meter_defines.svh"

module eprm_calc #(
    parameter int PW = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  eprm_pkg::t_calc_ctl        i_ctl,
    input  logic [PW-1:0]              i_pos,
    input  logic [PW-1:0]              i_ref_pos,
    input  logic [eprm_pkg::TS_W-1:0]  i_ts,
    input  logic [eprm_pkg::TS_W-1:0]  i_ref_time,
    input  logic [eprm_pkg::CFG_W-1:0] i_cpr,
    output eprm_pkg::t_calc_sts        o_sts
);
    import eprm_pkg::*;

    localparam int W = PW + FACTOR_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DT   = 4'd1;
    localparam logic [3:0] S_DIFF = 4'd2;
    localparam logic [3:0] S_ABS  = 4'd3;
    localparam logic [3:0] S_FDIV = 4'd4;
    localparam logic [3:0] S_MUL  = 4'd5;
    localparam logic [3:0] S_SAT  = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0]          r_state, n_state;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [TS_W-1:0]     r_dt, n_dt;
    logic [TS_W-1:0]     r_rem, n_rem;
    logic [PW-1:0]       r_mag, n_mag;
    logic [W-1:0]        r_prod, n_prod;
    logic [FACTOR_W-1:0] r_fq, n_fq;
    logic [SPEED_W-1:0]  r_quo, n_quo;
    logic [CFG_W-1:0]    r_cpr, n_cpr;

    logic [W-1:0] w_a, w_b, w_sum, w_prod_hi;
    logic         w_sub, w_ge;

    assign w_prod_hi = r_prod >> SPEED_W;

    eprm_alu #(.W(W)) u_alu (
        .i_a   (w_a),
        .i_b   (w_b),
        .i_sub (w_sub),
        .o_sum (w_sum),
        .o_ge  (w_ge)
    );

    // operand select for the shared adder
    always_comb begin
        w_a   = '0;
        w_b   = '0;
        w_sub = 1'b1;
        case (r_state)
            S_DT: begin
                w_a = W'(r_dt);
                w_b = W'(r_rem);
            end
            S_DIFF: begin
                w_a = W'(r_mag);
                w_b = W'(r_prod[PW-1:0]);
            end
            S_ABS: begin
                w_b = W'(r_mag);
            end
            S_FDIV: begin
                w_a = W'({r_rem[CFG_W-1:0], r_fq[FACTOR_W-1]});
                w_b = W'(r_cpr);
            end
            S_MUL: begin
                w_a   = r_prod << 1;
                w_b   = r_fq[FACTOR_W-1] ? W'(r_mag) : '0;
                w_sub = 1'b0;
            end
            S_SAT: begin
                w_a = w_prod_hi;
                w_b = W'(r_dt);
            end
            S_DIV: begin
                w_a = W'({r_rem, r_quo[SPEED_W-1]});
                w_b = W'(r_dt);
            end
            default: begin
                w_sub = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_dt    = r_dt;
        n_rem   = r_rem;
        n_mag   = r_mag;
        n_prod  = r_prod;
        n_fq    = r_fq;
        n_quo   = r_quo;
        n_cpr   = r_cpr;
        case (r_state)
            S_IDLE: begin
                if (i_ctl.start) begin
                    n_dt    = i_ts;
                    n_rem   = i_ref_time;
                    n_mag   = i_pos;
                    n_prod  = W'(i_ref_pos);
                    n_cpr   = (i_cpr == '0) ? CFG_W'(1) : i_cpr;
                    n_state = S_DT;
                end
            end
            S_DT: begin
                n_dt    = w_sum[TS_W-1:0];
                n_state = S_DIFF;
            end
            S_DIFF: begin
                n_mag   = w_sum[PW-1:0];
                n_state = S_ABS;
            end
            S_ABS: begin
                // negative delta: take the magnitude
                if (r_mag[PW-1]) begin
                    n_mag = w_sum[PW-1:0];
                end
                n_rem   = '0;
                n_fq    = RPM_NUMERATOR;
                n_cnt   = FACTOR_LAST;
                n_state = S_FDIV;
            end
            S_FDIV: begin
                n_rem = w_ge ? TS_W'(w_sum[CFG_W-1:0])
                             : TS_W'({r_rem[CFG_W-2:0], r_fq[FACTOR_W-1]});
                n_fq  = {r_fq[FACTOR_W-2:0], w_ge};
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_prod  = '0;
                    n_cnt   = FACTOR_LAST;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod = w_sum;
                n_fq   = {r_fq[FACTOR_W-2:0], 1'b0};
                n_cnt  = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_state = S_SAT;
                end
            end
            S_SAT: begin
                // quotient would not fit in 31 bits: clamp
                if (w_ge) begin
                    n_quo   = SPEED_MAX;
                    n_state = S_DONE;
                end else begin
                    n_rem   = w_prod_hi[TS_W-1:0];
                    n_quo   = r_prod[SPEED_W-1:0];
                    n_cnt   = DIV_LAST;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem = w_ge ? w_sum[TS_W-1:0] : {r_rem[TS_W-2:0], r_quo[SPEED_W-1]};
                n_quo = {r_quo[SPEED_W-2:0], w_ge};
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_ctl.ack) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_dt   <= n_dt;
        r_rem  <= n_rem;
        r_mag  <= n_mag;
        r_prod <= n_prod;
        r_fq   <= n_fq;
        r_quo  <= n_quo;
        r_cpr  <= n_cpr;
    end

    assign o_sts.done  = (r_state == S_DONE);
    assign o_sts.speed = r_quo;

    `EPRM_ASSERT_IMPLY(a_start_idle, i_ctl.start, r_state == S_IDLE, "start while busy")
    `EPRM_ASSERT_NEXT(a_done_hold, o_sts.done && !i_ctl.ack, o_sts.done && $stable(o_sts.speed), "result dropped before ack")
    `EPRM_ASSERT_NEXT(a_ack_idle, i_ctl.ack, r_state == S_IDLE, "no return to idle after ack")

endmodule

`default_nettype wire
